>>> src/rsb_pkg.sv
// Shared types and constants for the reservoir sample buffer.
`timescale 1ns / 1ps

package rsb_pkg;

  localparam int DATA_W = 32;  // entry, random value and seen counter width
  localparam int FILL_W = 11;  // fill count and capacity width
  localparam int SLOT_W = 10;  // reported slot width

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_DRAW = 1'b1;

  localparam logic [FILL_W-1:0] CAP_RESET = 11'd1024;
  localparam logic [DATA_W-1:0] SEEN_MAX  = 32'hFFFF_FFFF;

  // Request to the remainder unit.
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } rsb_div_req_t;

  // Response from the remainder unit; remainder holds after done.
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] remainder;
  } rsb_div_rsp_t;

endpackage

>>> src/rsb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rsb_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/rsb_rem_unit.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps

module rsb_rem_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rsb_pkg::rsb_div_req_t req,
  output rsb_pkg::rsb_div_rsp_t rsp
);

  import rsb_pkg::*;

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic [DATA_W-1:0] dvd_r, dvd_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [DATA_W:0]   trial;

  always_comb begin
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[DATA_W-1]};
    if (req.start) begin
      dvd_nxt = req.dividend;
      dvs_nxt = req.divisor;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(DATA_W);
    end else if (cnt_r != '0) begin
      // partial remainder stays below the divisor, so 33 bits suffice
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DATA_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[DATA_W-1:0];
      end
      dvd_nxt = {dvd_r[DATA_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;

endmodule

>>> src/reservoir_sample_buffer_top.sv
// Reservoir sample buffer top level: sequencer, entry store and remainder unit.
`timescale 1ns / 1ps
//
// Reservoir sampling store (algorithm R) of entry handles.
// Input: an item transfers on a clock edge with start high and busy low.
//   in_action picks push or draw; in_random_value supplies the slot choice.
// Output: one result per item, shown for exactly one cycle with out_valid.
//   The receiver cannot stall; every result must be taken on that edge.
// Config: cfg_we/cfg_wdata writes capacity; write only while busy is low.
// Timing:
//   - push while not full, or draw from empty store: result in the cycle after
//     the transfer, busy never rises, next item may follow at once.
//   - push with a full store: bit-serial remainder by the seen count, then
//     the store write if the slot is below capacity, and the result.
//   - draw from a filled store: bit-serial remainder by the fill count, then
//     a registered store read, and the result.
//   The remainder unit is the long step; one item is worked at a time.
// Reset (rst_n low, synchronous): fill and seen counts clear, capacity
//   returns to 1024. Store contents are not cleared; only filled slots
//   are ever read.

module reservoir_sample_buffer_top #(
  parameter int DEPTH      = 1024,
  parameter int ENTRY_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_action,
  input  logic [rsb_pkg::DATA_W-1:0]   in_entry,
  input  logic [rsb_pkg::DATA_W-1:0]   in_random_value,
  input  logic                         cfg_we,
  input  logic [rsb_pkg::FILL_W-1:0]   cfg_wdata,
  output logic                         out_valid,
  output logic                         out_written,
  output logic                         out_found,
  output logic [rsb_pkg::SLOT_W-1:0]   out_slot,
  output logic [rsb_pkg::DATA_W-1:0]   out_drawn_entry,
  output logic [rsb_pkg::FILL_W-1:0]   out_fill_count,
  output logic [rsb_pkg::DATA_W-1:0]   out_seen_total
);

  import rsb_pkg::*;

  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_LIM = (DEPTH > 2047) ? 2047 : DEPTH;
  localparam logic [FILL_W-1:0] CAP_MAX = FILL_W'(CAP_LIM);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_READ} state_t;

  state_t            state_r, state_nxt;
  logic [FILL_W-1:0] cap_r;
  logic [FILL_W-1:0] filled_r, filled_nxt;
  logic [DATA_W-1:0] seen_r, seen_nxt;
  logic              act_r, act_nxt;
  logic [DATA_W-1:0] entry_r, entry_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_written_r, out_written_nxt;
  logic              out_found_r, out_found_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [DATA_W-1:0] out_drawn_r, out_drawn_nxt;
  logic [FILL_W-1:0] out_fill_r, out_fill_nxt;
  logic [DATA_W-1:0] out_seen_r, out_seen_nxt;

  logic [FILL_W-1:0] cap_use;
  logic              accept;
  logic [DATA_W-1:0] seen_inc;
  logic [DATA_W-1:0] filled_ext;
  logic [63:0]       wr_ext;
  logic [63:0]       rd_ext;

  rsb_div_req_t      div_req;
  rsb_div_rsp_t      div_rsp;

  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [ENTRY_BITS-1:0] ram_wdata, ram_rdata;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign cap_use  = (cap_r > CAP_MAX) ? CAP_MAX : cap_r;
  assign seen_inc = (seen_r == SEEN_MAX) ? seen_r : seen_r + 1'b1;
  assign filled_ext = DATA_W'(filled_r);
  assign rd_ext   = 64'(ram_rdata);

  // capacity register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    filled_nxt      = filled_r;
    seen_nxt        = seen_r;
    act_nxt         = act_r;
    entry_nxt       = entry_r;
    slot_nxt        = slot_r;
    out_valid_nxt   = 1'b0;
    out_written_nxt = out_written_r;
    out_found_nxt   = out_found_r;
    out_slot_nxt    = out_slot_r;
    out_drawn_nxt   = out_drawn_r;
    out_fill_nxt    = out_fill_r;
    out_seen_nxt    = out_seen_r;
    div_req.start    = 1'b0;
    div_req.dividend = in_random_value;
    div_req.divisor  = filled_ext;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = filled_ext[ADDR_W-1:0];
    ram_raddr = div_rsp.remainder[ADDR_W-1:0];
    wr_ext    = 64'(in_entry);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          act_nxt   = in_action;
          entry_nxt = in_entry;
          if (in_action == ACT_PUSH) begin
            seen_nxt = seen_inc;
            if (filled_r < cap_use) begin
              // append at the next free slot
              ram_we          = 1'b1;
              filled_nxt      = filled_r + 1'b1;
              out_valid_nxt   = 1'b1;
              out_written_nxt = 1'b1;
              out_found_nxt   = 1'b0;
              out_slot_nxt    = filled_r[SLOT_W-1:0];
              out_drawn_nxt   = '0;
              out_fill_nxt    = filled_r + 1'b1;
              out_seen_nxt    = seen_inc;
            end else begin
              // replacement: slot = random mod seen (seen is nonzero here)
              div_req.start   = 1'b1;
              div_req.divisor = seen_inc;
              state_nxt       = ST_DIV;
            end
          end else if (filled_r == '0) begin
            out_valid_nxt   = 1'b1;
            out_written_nxt = 1'b0;
            out_found_nxt   = 1'b0;
            out_slot_nxt    = '0;
            out_drawn_nxt   = '0;
            out_fill_nxt    = filled_r;
            out_seen_nxt    = seen_r;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          slot_nxt = div_rsp.remainder[SLOT_W-1:0];
          if (act_r == ACT_PUSH) begin
            wr_ext          = 64'(entry_r);
            ram_waddr       = div_rsp.remainder[ADDR_W-1:0];
            ram_we          = (div_rsp.remainder < DATA_W'(cap_use));
            out_valid_nxt   = 1'b1;
            out_written_nxt = ram_we;
            out_found_nxt   = 1'b0;
            out_slot_nxt    = ram_we ? div_rsp.remainder[SLOT_W-1:0] : '0;
            out_drawn_nxt   = '0;
            out_fill_nxt    = filled_r;
            out_seen_nxt    = seen_r;
            state_nxt       = ST_IDLE;
          end else begin
            // remainder is below the fill count, so the slot was written
            ram_re    = 1'b1;
            state_nxt = ST_READ;
          end
        end
      end

      ST_READ: begin
        out_valid_nxt   = 1'b1;
        out_written_nxt = 1'b0;
        out_found_nxt   = 1'b1;
        out_slot_nxt    = slot_r;
        out_drawn_nxt   = rd_ext[DATA_W-1:0];
        out_fill_nxt    = filled_r;
        out_seen_nxt    = seen_r;
        state_nxt       = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    ram_wdata = wr_ext[ENTRY_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      filled_r    <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filled_r    <= filled_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r         <= act_nxt;
    entry_r       <= entry_nxt;
    slot_r        <= slot_nxt;
    out_written_r <= out_written_nxt;
    out_found_r   <= out_found_nxt;
    out_slot_r    <= out_slot_nxt;
    out_drawn_r   <= out_drawn_nxt;
    out_fill_r    <= out_fill_nxt;
    out_seen_r    <= out_seen_nxt;
  end

  rsb_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rsb_ram #(
    .WIDTH  (ENTRY_BITS),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_written     = out_written_r;
  assign out_found       = out_found_r;
  assign out_slot        = out_slot_r;
  assign out_drawn_entry = out_drawn_r;
  assign out_fill_count  = out_fill_r;
  assign out_seen_total  = out_seen_r;

`ifndef SYNTHESIS
  // a result always lands with the sequencer back in idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result transfer while busy");

  // fill count never passes the usable store size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CAP_MAX)
    else $error("fill count beyond store size");

  // remainder done in the divide state leads to a result or a store read
  a_div_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_rsp.done) |=> (out_valid || state_r == ST_READ))
    else $error("remainder completion lost");

  // a draw only finds an entry in a nonempty store
  a_found_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_fill_count != '0))
    else $error("draw found entry in empty store");
`endif

endmodule
